FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is held
`define CHK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked property that also holds through reset
`define CHK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

FILE: rtl/core/sli_pkg.sv
// types and codes shared by the sorted list blocks
package sli_pkg;

    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] t_word;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // result of the shared comparator
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

endpackage

FILE: rtl/core/sorted_list_insert_delete.sv
// sorted store of signed words with insert and delete under a small sequencer
//
//  channel   direction  handshake             payload
//  request   in         i_valid / o_stall     i_operation, i_value
//  result    out        o_valid / i_stall     o_status, o_rank, o_entry_count,
//                                             o_smallest, o_largest
//
// an item is handled step by step: each entry visited needs its own read and then a
// compare or a write, since the single read port of the entry memory serves every step;
// a delete from an empty store goes straight to the result.
// o_stall is high from the cycle after a request transfer until its result is
// registered; a result waiting on i_stall does not hold back the next request.
// reset (synchronous, active low) empties the store; entry contents need no clearing.
module sorted_list_insert_delete import sli_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  t_word       i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [3:0]  o_rank,
    output logic [4:0]  o_entry_count,
    output t_word       o_smallest,
    output t_word       o_largest
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_RD  = 4'd1;
    localparam logic [3:0] S_INS_CMP = 4'd2;
    localparam logic [3:0] S_INS_PUT = 4'd3;
    localparam logic [3:0] S_DEL_RD  = 4'd4;
    localparam logic [3:0] S_DEL_CMP = 4'd5;
    localparam logic [3:0] S_SH_RD   = 4'd6;
    localparam logic [3:0] S_SH_WR   = 4'd7;
    localparam logic [3:0] S_MIN_RD  = 4'd8;
    localparam logic [3:0] S_MAX_RD  = 4'd9;
    localparam logic [3:0] S_FIN     = 4'd10;

    logic [3:0]    r_state, n_state;
    logic          r_op, n_op;
    t_word         r_value, n_value;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_rank, n_rank;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_status, n_status;
    t_word         r_small, n_small;

    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_res_status, n_res_status;
    logic [3:0]    r_res_rank, n_res_rank;
    logic [4:0]    r_res_count, n_res_count;
    t_word         r_res_small, n_res_small;
    t_word         r_res_large, n_res_large;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_word         wr_data;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    t_word         rd_data;
    t_word         cmp_a;
    t_word         cmp_b;
    t_cmp          cmp;
    logic          last;
    logic [31:0]   rank_w;
    logic [31:0]   count_w;

    sli_store #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // insert looks for value < entry, delete for entry < value
    assign cmp_a = (r_op == OP_INSERT) ? r_value : rd_data;
    assign cmp_b = (r_op == OP_INSERT) ? rd_data : r_value;

    sli_cmp u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_res (cmp)
    );

    assign last    = (CW'(r_idx) == (r_count - CW'(1)));
    assign rank_w  = 32'(r_rank);
    assign count_w = 32'(r_count);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_value      = r_value;
        n_idx        = r_idx;
        n_rank       = r_rank;
        n_count      = r_count;
        n_status     = r_status;
        n_small      = r_small;
        n_out_valid  = r_out_valid & i_stall;
        n_res_status = r_res_status;
        n_res_rank   = r_res_rank;
        n_res_count  = r_res_count;
        n_res_small  = r_res_small;
        n_res_large  = r_res_large;
        wr_en        = 1'b0;
        wr_addr      = r_idx;
        wr_data      = r_value;
        rd_en        = 1'b0;
        rd_addr      = r_idx;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op     = i_operation;
                    n_value  = i_value;
                    n_rank   = '0;
                    n_status = ST_DONE;
                    if (i_operation == OP_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_MIN_RD;
                        end else if (r_count == '0) begin
                            wr_en   = 1'b1;
                            wr_addr = '0;
                            wr_data = i_value;
                            n_count = CW'(1);
                            n_state = S_MIN_RD;
                        end else begin
                            // scan down from the top, moving larger entries up
                            n_idx   = IW'(r_count - CW'(1));
                            n_state = S_INS_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_FIN;
                        end else begin
                            n_idx   = '0;
                            n_state = S_DEL_RD;
                        end
                    end
                end
            end
            S_INS_RD: begin
                rd_en   = 1'b1;
                n_state = S_INS_CMP;
            end
            S_INS_CMP: begin
                wr_en   = 1'b1;
                wr_addr = r_idx + IW'(1);
                if (cmp.lt) begin
                    wr_data = rd_data;
                    if (r_idx == '0) begin
                        n_state = S_INS_PUT;
                    end else begin
                        n_idx   = r_idx - IW'(1);
                        n_state = S_INS_RD;
                    end
                end else begin
                    // new value goes after all equal entries
                    wr_data = r_value;
                    n_rank  = r_idx + IW'(1);
                    n_count = r_count + CW'(1);
                    n_state = S_MIN_RD;
                end
            end
            S_INS_PUT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = r_value;
                n_rank  = '0;
                n_count = r_count + CW'(1);
                n_state = S_MIN_RD;
            end
            S_DEL_RD: begin
                rd_en   = 1'b1;
                n_state = S_DEL_CMP;
            end
            S_DEL_CMP: begin
                if (cmp.lt) begin
                    if (last) begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_MIN_RD;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = S_DEL_RD;
                    end
                end else if (cmp.eq) begin
                    n_rank  = r_idx;
                    n_count = r_count - CW'(1);
                    if (!last) begin
                        n_state = S_SH_RD;
                    end else if (r_count == CW'(1)) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_MIN_RD;
                    end
                end else begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_MIN_RD;
                end
            end
            S_SH_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_idx + IW'(1);
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                // count already holds the reduced value here
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = rd_data;
                if (last) begin
                    n_state = S_MIN_RD;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_SH_RD;
                end
            end
            S_MIN_RD: begin
                rd_en   = 1'b1;
                rd_addr = '0;
                n_state = S_MAX_RD;
            end
            S_MAX_RD: begin
                n_small = rd_data;
                rd_en   = 1'b1;
                rd_addr = IW'(r_count - CW'(1));
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!(r_out_valid && i_stall)) begin
                    n_out_valid  = 1'b1;
                    n_res_status = r_status;
                    n_res_rank   = (r_status == ST_DONE) ? rank_w[3:0] : 4'd0;
                    n_res_count  = count_w[4:0];
                    n_res_small  = (r_count == '0) ? '0 : r_small;
                    n_res_large  = (r_count == '0) ? '0 : rd_data;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_value      <= n_value;
        r_idx        <= n_idx;
        r_rank       <= n_rank;
        r_status     <= n_status;
        r_small      <= n_small;
        r_res_status <= n_res_status;
        r_res_rank   <= n_res_rank;
        r_res_count  <= n_res_count;
        r_res_small  <= n_res_small;
        r_res_large  <= n_res_large;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_res_status;
    assign o_rank        = r_res_rank;
    assign o_entry_count = r_res_count;
    assign o_smallest    = r_res_small;
    assign o_largest     = r_res_large;

endmodule

FILE: rtl/core/sli_store.sv
// entry memory: one write port, one registered read port
module sli_store import sli_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_word         i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_word         o_rd_data
);

    t_word r_mem [DEPTH];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/sli_cmp.sv
// shared signed comparator used by every search step
module sli_cmp import sli_pkg::*; (
    input  t_word i_a,
    input  t_word i_b,
    output t_cmp  o_res
);

    always_comb begin
        o_res.lt = (i_a < i_b);
        o_res.eq = (i_a == i_b);
    end

endmodule

FILE: rtl/core/sli_checker.sv
// port-level checks for the sorted list block, bound to the top level
`include "assert_macros.svh"

module sli_checker import sli_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_operation,
    input t_word       i_value,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [3:0]  o_rank,
    input logic [4:0]  o_entry_count,
    input t_word       o_smallest,
    input t_word       o_largest
);

    // a request transfer always makes the block busy in the following cycle
    `CHK_RST(a_busy_after_req, i_clk, i_rst_n, (i_valid && !o_stall) |=> o_stall)

    // a stalled request holds its payload
    `CHK_RST(a_req_hold, i_clk, i_rst_n,
             (i_valid && o_stall) |=>
             (i_valid && $stable(i_operation) && $stable(i_value)))

    // a stalled result holds its payload
    `CHK_RST(a_res_hold, i_clk, i_rst_n,
             (o_valid && i_stall) |=>
             (o_valid && $stable(o_status) && $stable(o_rank) &&
              $stable(o_entry_count) && $stable(o_smallest) && $stable(o_largest)))

    // failed operations report rank zero and only known status codes appear
    `CHK_RST(a_fail_rank, i_clk, i_rst_n,
             (o_valid && (o_status != ST_DONE)) |->
             ((o_rank == 4'd0) && ((o_status == ST_NOT_FOUND) || (o_status == ST_FULL))))

    // minimum never exceeds maximum
    `CHK_RST(a_min_max, i_clk, i_rst_n, o_valid |-> (o_smallest <= o_largest))

endmodule

bind sorted_list_insert_delete sli_checker u_sli_checker (.*);
